// ===== hw/rtl/dsdl_pkg.sv =====
// ----------------------------------------------------------------------------
// dsdl_pkg
// Shared types and constants for the depth-sorted draw list.
// ----------------------------------------------------------------------------
package dsdl_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int TAG_W      = 10;
  localparam int COORD_W    = 20;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int FRAC_SQ_W  = 8;   // Q.4 squared gives 8 fraction bits
  localparam int DIST_W     = 34;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CAMERA_X = 2'd0,
    REG_CAMERA_Y = 2'd1,
    REG_CAMERA_Z = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_ADDED = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_ENTRY = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_INSERT,
    ST_DRAIN
  } state_e;

  // One list entry
  typedef struct packed {
    dist_t distance;
    tag_t  tag;
  } entry_t;

  // Broadcast control to every cell of the list
  typedef struct packed {
    logic   insert;
    logic   drain;
    entry_t key;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/dsdl_dist.sv =====
// ----------------------------------------------------------------------------
// dsdl_dist
// Three-stage squared distance: axis differences, squares, sum and scale.
// ----------------------------------------------------------------------------
module dsdl_dist (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dsdl_pkg::coord_t pos_x_i,
  input  dsdl_pkg::coord_t pos_y_i,
  input  dsdl_pkg::coord_t pos_z_i,
  input  dsdl_pkg::coord_t cam_x_i,
  input  dsdl_pkg::coord_t cam_y_i,
  input  dsdl_pkg::coord_t cam_z_i,
  output logic             done_o,
  output dsdl_pkg::dist_t  dist_o
);

  logic [2:0] vld_q, vld_d;

  logic signed [dsdl_pkg::DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [dsdl_pkg::DIFF_W-1:0] dx_d, dy_d, dz_d;
  logic signed [dsdl_pkg::SQ_W-1:0]   sx_q, sy_q, sz_q;
  logic signed [dsdl_pkg::SQ_W-1:0]   sx_d, sy_d, sz_d;
  logic [dsdl_pkg::SUM_W-1:0]         sum_d;
  dsdl_pkg::dist_t                    dist_q, dist_d;

  // Stage 1: exact 21-bit differences
  assign dx_d = $signed({pos_x_i[dsdl_pkg::COORD_W-1], pos_x_i})
              - $signed({cam_x_i[dsdl_pkg::COORD_W-1], cam_x_i});
  assign dy_d = $signed({pos_y_i[dsdl_pkg::COORD_W-1], pos_y_i})
              - $signed({cam_y_i[dsdl_pkg::COORD_W-1], cam_y_i});
  assign dz_d = $signed({pos_z_i[dsdl_pkg::COORD_W-1], pos_z_i})
              - $signed({cam_z_i[dsdl_pkg::COORD_W-1], cam_z_i});

  // Stage 2: one multiplier per axis
  assign sx_d = dx_q * dx_q;
  assign sy_d = dy_q * dy_q;
  assign sz_d = dz_q * dz_q;

  // Stage 3: sum of non-negative squares, drop the fraction
  assign sum_d = {2'b00, sx_q} + {2'b00, sy_q} + {2'b00, sz_q};
  assign dist_d = sum_d[dsdl_pkg::DIST_W+dsdl_pkg::FRAC_SQ_W-1:dsdl_pkg::FRAC_SQ_W];

  assign vld_d = {vld_q[1:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
    end
    if (vld_q[0]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      sz_q <= sz_d;
    end
    if (vld_q[1]) begin
      dist_q <= dist_d;
    end
  end

  assign done_o = vld_q[2];
  assign dist_o = dist_q;

endmodule

// ===== hw/rtl/dsdl_cell.sv =====
// ----------------------------------------------------------------------------
// dsdl_cell
// One slot of the sorted list; shifts down on insert, up on drain.
// ----------------------------------------------------------------------------
module dsdl_cell (
  input  logic                 clk_i,
  input  dsdl_pkg::cell_ctrl_t ctrl_i,
  input  logic                 occupied_i,
  input  logic                 prev_ge_i,
  input  dsdl_pkg::entry_t     prev_entry_i,
  input  dsdl_pkg::entry_t     next_entry_i,
  output logic                 ge_o,
  output dsdl_pkg::entry_t     entry_o
);

  dsdl_pkg::entry_t entry_q, entry_d;

  // Stored entry sorts ahead of the key (equal distance stays ahead)
  assign ge_o = occupied_i && (entry_q.distance >= ctrl_i.key.distance);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!prev_ge_i) begin
        entry_d = prev_entry_i;
      end else if (!ge_o) begin
        entry_d = ctrl_i.key;
      end
    end else if (ctrl_i.drain) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/depth_sorted_draw_list_core.sv =====
// ----------------------------------------------------------------------------
// depth_sorted_draw_list_core
// Draw list kept in descending squared distance to a camera.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries op, tag and position.
//   An add computes the squared distance in a three-stage pipeline and,
//   unless the list is full, inserts it into a chain of list cells; one result
//   (added or full) follows once the output register is free. The next input is
//   taken only after that result is registered, so adds do not overlap.
//   A drain shifts the chain toward cell 0 and emits one entry per cycle while
//   the receiver keeps up, farthest first, last set on the final one;
//   an empty list gives one empty marker.
//   Output channel (out_valid_o/out_ready_i) has a single output register;
//   while the receiver stalls, inserts and drain shifts wait for it.
//   The camera registers sit on an APB port at byte offsets 0, 4, 8; they are
//   to be written only while the block is idle; the block does not enforce it.
//   Reset empties the list (count to zero) and clears the camera to zero;
//   list cells hold no reset value.
// ----------------------------------------------------------------------------
module depth_sorted_draw_list_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [dsdl_pkg::TAG_W-1:0]    entity_tag_i,
  input  logic signed [dsdl_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [dsdl_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [dsdl_pkg::COORD_W-1:0] pos_z_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [dsdl_pkg::TAG_W-1:0]    out_tag_o,
  output logic [dsdl_pkg::DIST_W-1:0]   out_distance_o,
  output logic                          last_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dsdl_pkg::ADDR_W-1:0]   paddr,
  input  logic [dsdl_pkg::DATA_W-1:0]   pwdata,
  output logic [dsdl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int N = dsdl_pkg::LIST_DEPTH;

  dsdl_pkg::state_e     state_q, state_d;
  dsdl_pkg::cnt_t       count_q, count_d;
  dsdl_pkg::tag_t       tag_q;
  dsdl_pkg::coord_t     cam_x_q, cam_y_q, cam_z_q;
  dsdl_pkg::reg_idx_e   reg_idx;

  logic                 out_valid_q, out_valid_d;
  dsdl_pkg::status_e    out_status_q, out_status_d;
  dsdl_pkg::tag_t       out_tag_q, out_tag_d;
  dsdl_pkg::dist_t      out_dist_q, out_dist_d;
  logic                 out_last_q, out_last_d;

  logic                 in_xfer, slot_free, full;
  logic                 dist_done;
  dsdl_pkg::dist_t      key_dist;
  dsdl_pkg::cell_ctrl_t ctrl;

  logic                 occ [N];
  logic                 ge  [N];
  dsdl_pkg::entry_t     ent [N];

  // APB: always ready, write on access phase
  assign pready  = 1'b1;
  assign reg_idx = dsdl_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        dsdl_pkg::REG_CAMERA_X: cam_x_q <= pwdata[dsdl_pkg::COORD_W-1:0];
        dsdl_pkg::REG_CAMERA_Y: cam_y_q <= pwdata[dsdl_pkg::COORD_W-1:0];
        dsdl_pkg::REG_CAMERA_Z: cam_z_q <= pwdata[dsdl_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dsdl_pkg::REG_CAMERA_X: prdata = {{(dsdl_pkg::DATA_W-dsdl_pkg::COORD_W){1'b0}}, cam_x_q};
      dsdl_pkg::REG_CAMERA_Y: prdata = {{(dsdl_pkg::DATA_W-dsdl_pkg::COORD_W){1'b0}}, cam_y_q};
      dsdl_pkg::REG_CAMERA_Z: prdata = {{(dsdl_pkg::DATA_W-dsdl_pkg::COORD_W){1'b0}}, cam_z_q};
      default:                prdata = '0;
    endcase
  end

  // Distance pipeline
  dsdl_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer && (op_i == dsdl_pkg::OP_ADD)),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pos_z_i (pos_z_i),
    .cam_x_i (cam_x_q),
    .cam_y_i (cam_y_q),
    .cam_z_i (cam_z_q),
    .done_o  (dist_done),
    .dist_o  (key_dist)
  );

  // Chain of list cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i] = (count_q > dsdl_pkg::cnt_t'(i));
    if (i == 0) begin : g_head
      dsdl_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occupied_i   (occ[i]),
        .prev_ge_i    (1'b1),
        .prev_entry_i (ctrl.key),
        .next_entry_i (ent[i+1]),
        .ge_o         (ge[i]),
        .entry_o      (ent[i])
      );
    end else if (i == N - 1) begin : g_tail
      dsdl_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occupied_i   (occ[i]),
        .prev_ge_i    (ge[i-1]),
        .prev_entry_i (ent[i-1]),
        .next_entry_i (ctrl.key),
        .ge_o         (ge[i]),
        .entry_o      (ent[i])
      );
    end else begin : g_mid
      dsdl_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occupied_i   (occ[i]),
        .prev_ge_i    (ge[i-1]),
        .prev_entry_i (ent[i-1]),
        .next_entry_i (ent[i+1]),
        .ge_o         (ge[i]),
        .entry_o      (ent[i])
      );
    end
  end

  assign in_ready_o = (state_q == dsdl_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign full       = (count_q == dsdl_pkg::cnt_t'(N));

  // Sequencer: next state, list control and output register load
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    out_dist_d   = out_dist_q;
    out_last_d   = out_last_q;
    ctrl.insert  = 1'b0;
    ctrl.drain   = 1'b0;
    ctrl.key.distance = key_dist;
    ctrl.key.tag      = tag_q;
    case (state_q)
      dsdl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (op_i == dsdl_pkg::OP_ADD) begin
            state_d = dsdl_pkg::ST_CALC;
          end else begin
            state_d = dsdl_pkg::ST_DRAIN;
          end
        end
      end
      dsdl_pkg::ST_CALC: begin
        if (dist_done) begin
          state_d = dsdl_pkg::ST_INSERT;
        end
      end
      dsdl_pkg::ST_INSERT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_tag_d   = '0;
          out_dist_d  = key_dist;
          out_last_d  = 1'b1;
          if (full) begin
            out_status_d = dsdl_pkg::STATUS_FULL;
          end else begin
            out_status_d = dsdl_pkg::STATUS_ADDED;
            ctrl.insert  = 1'b1;
            count_d      = count_q + dsdl_pkg::cnt_t'(1);
          end
          state_d = dsdl_pkg::ST_IDLE;
        end
      end
      dsdl_pkg::ST_DRAIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_status_d = dsdl_pkg::STATUS_EMPTY;
            out_tag_d    = '0;
            out_dist_d   = '0;
            out_last_d   = 1'b1;
            state_d      = dsdl_pkg::ST_IDLE;
          end else begin
            out_status_d = dsdl_pkg::STATUS_ENTRY;
            out_tag_d    = ent[0].tag;
            out_dist_d   = ent[0].distance;
            out_last_d   = (count_q == dsdl_pkg::cnt_t'(1));
            ctrl.drain   = 1'b1;
            count_d      = count_q - dsdl_pkg::cnt_t'(1);
            if (count_q == dsdl_pkg::cnt_t'(1)) begin
              state_d = dsdl_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = dsdl_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsdl_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tag_q <= entity_tag_i;
    end
    out_status_q <= out_status_d;
    out_tag_q    <= out_tag_d;
    out_dist_q   <= out_dist_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_tag_o      = out_tag_q;
  assign out_distance_o = out_dist_q;
  assign last_o         = out_last_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the depth-sorted draw list. A driver process offers
// add and drain items from a pending queue and predicts the results of each
// accepted item. A monitor process checks every result in order. The camera
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import dsdl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  localparam coord_t COORD_MIN = 20'h80000;
  localparam coord_t COORD_MAX = 20'h7FFFF;

  // One input item and one result
  typedef struct {
    op_e    op;
    tag_t   tag;
    coord_t x;
    coord_t y;
    coord_t z;
  } draw_item_t;

  typedef struct {
    status_e status;
    tag_t    tag;
    dist_t   distance;
    logic    last;
  } draw_result_t;

  // DUT connections
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                op_i         = 1'b0;
  tag_t                entity_tag_i = '0;
  logic signed [COORD_W-1:0] pos_x_i = '0;
  logic signed [COORD_W-1:0] pos_y_i = '0;
  logic signed [COORD_W-1:0] pos_z_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [1:0]          status_o;
  tag_t                out_tag_o;
  dist_t               out_distance_o;
  logic                last_o;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Stimulus and scoreboard state
  draw_item_t   pending_q[$];
  draw_result_t drawn_q[$];
  draw_item_t   offered;
  int           queued_cnt   = 0;
  int           accepted_cnt = 0;
  int           fail_cnt     = 0;
  int           cycle_cnt    = 0;
  bit           no_idle      = 1'b0;
  bit           hold_req     = 1'b0;
  bit           hold_done    = 1'b0;
  int           hold_left    = 0;
  int           snd_gap      = 0;
  int           snd_calm     = 0;
  int           rcv_gap      = 0;
  int           rcv_calm     = 0;

  // Shadow of the camera and the sorted list
  coord_t cam_x = '0;
  coord_t cam_y = '0;
  coord_t cam_z = '0;
  dist_t  list_dist[LIST_DEPTH];
  tag_t   list_tag[LIST_DEPTH];
  int     list_cnt = 0;

  depth_sorted_draw_list_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .entity_tag_i   (entity_tag_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_tag_o      (out_tag_o),
    .out_distance_o (out_distance_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Integer part of the squared distance to the camera
  function automatic dist_t sq_distance(coord_t px, coord_t py, coord_t pz);
    longint dx, dy, dz, sum;
    dx  = longint'($signed(px)) - longint'($signed(cam_x));
    dy  = longint'($signed(py)) - longint'($signed(cam_y));
    dz  = longint'($signed(pz)) - longint'($signed(cam_z));
    sum = dx * dx + dy * dy + dz * dz;
    return dist_t'(sum >> FRAC_SQ_W);
  endfunction

  function automatic draw_result_t mk_result(status_e st, tag_t t, dist_t d, logic l);
    draw_result_t res;
    res.status   = st;
    res.tag      = t;
    res.distance = d;
    res.last     = l;
    return res;
  endfunction

  // Update the shadow list for one accepted item and queue its results
  task automatic predict_item(draw_item_t it);
    dist_t d;
    int    k;
    if (it.op == OP_ADD) begin
      d = sq_distance(it.x, it.y, it.z);
      if (list_cnt >= LIST_DEPTH) begin
        drawn_q.push_back(mk_result(STATUS_FULL, '0, d, 1'b1));
      end else begin
        // ties stay ahead of the new entry
        k = list_cnt;
        while (k > 0 && list_dist[k-1] < d) begin
          list_dist[k] = list_dist[k-1];
          list_tag[k]  = list_tag[k-1];
          k--;
        end
        list_dist[k] = d;
        list_tag[k]  = it.tag;
        list_cnt++;
        drawn_q.push_back(mk_result(STATUS_ADDED, '0, d, 1'b1));
      end
    end else begin
      if (list_cnt == 0) begin
        drawn_q.push_back(mk_result(STATUS_EMPTY, '0, '0, 1'b1));
      end else begin
        for (k = 0; k < list_cnt; k++) begin
          drawn_q.push_back(mk_result(STATUS_ENTRY, list_tag[k], list_dist[k],
                                      (k + 1 == list_cnt)));
        end
      end
      list_cnt = 0;
    end
  endtask

  // Item builders
  function automatic draw_item_t add_item(tag_t t, coord_t x, coord_t y, coord_t z);
    draw_item_t it;
    it.op  = OP_ADD;
    it.tag = t;
    it.x   = x;
    it.y   = y;
    it.z   = z;
    return it;
  endfunction

  function automatic draw_item_t drain_item();
    draw_item_t it;
    it.op  = OP_DRAIN;
    it.tag = tag_t'($urandom);
    it.x   = coord_t'($urandom);
    it.y   = coord_t'($urandom);
    it.z   = coord_t'($urandom);
    return it;
  endfunction

  // One coordinate: anywhere, at an extreme, or close to the camera so that
  // distances repeat often
  function automatic coord_t rand_axis(coord_t base);
    int r, off;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return coord_t'($urandom);
    end else if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return COORD_MIN;
        1:       return COORD_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end else begin
      off = int'($urandom_range(0, 4)) * 16 - 32;
      return coord_t'(int'($signed(base)) + off);
    end
  endfunction

  function automatic draw_item_t rand_add();
    return add_item(tag_t'($urandom), rand_axis(cam_x), rand_axis(cam_y),
                    rand_axis(cam_z));
  endfunction

  task automatic push_item(draw_item_t it);
    pending_q.push_back(it);
    queued_cnt++;
  endtask

  // Mostly bursts of adds closed by a drain, plus stray drains and adds
  task automatic queue_random(int n);
    int done_n, burst, r, k;
    done_n = 0;
    while (done_n < n) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        push_item(drain_item());
        done_n++;
      end else if (r == 1) begin
        push_item(rand_add());
        done_n++;
      end else begin
        burst = $urandom_range(1, 12);
        for (k = 0; k < burst; k++) push_item(rand_add());
        push_item(drain_item());
        done_n += burst + 1;
      end
    end
  endtask

  // APB write: setup cycle, then access cycle
  task automatic apb_write(reg_idx_e idx, coord_t val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(DATA_W-COORD_W){val[COORD_W-1]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_camera(coord_t x, coord_t y, coord_t z);
    apb_write(REG_CAMERA_X, x);
    apb_write(REG_CAMERA_Y, y);
    apb_write(REG_CAMERA_Z, z);
    cam_x = x;
    cam_y = y;
    cam_z = z;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || drawn_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Driver: offer pending items, predict on each transfer
  always @(posedge clk_i) begin : drv
    logic busy;
    int   r;
    if (rst_ni) begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_item(offered);
        accepted_cnt++;
        busy = 1'b0;
      end
      if (!busy) begin
        r = $urandom_range(0, 9);
        if (snd_gap > 0) begin
          snd_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!no_idle && snd_calm == 0 && r < 2) begin
          snd_gap = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else begin
          if (snd_calm > 0) snd_calm--;
          else if (!no_idle && r == 2) snd_calm = $urandom_range(10, 40);
          offered = pending_q.pop_front();
          in_valid_i   <= 1'b1;
          op_i         <= offered.op;
          entity_tag_i <= offered.tag;
          pos_x_i      <= offered.x;
          pos_y_i      <= offered.y;
          pos_z_i      <= offered.z;
        end
      end
    end
  end

  // Monitor: check each result transfer, pace the receiver
  always @(posedge clk_i) begin : mon
    draw_result_t want;
    int           r;
    string        exp_s;
    string        got_s;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (drawn_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result: status %0d tag %0d dist %0d last %0d",
                   $time, status_o, out_tag_o, out_distance_o, last_o);
        end else begin
          want = drawn_q.pop_front();
          if (status_o !== want.status || out_tag_o !== want.tag ||
              out_distance_o !== want.distance || last_o !== want.last) begin
            fail_cnt++;
            exp_s = $sformatf("status %0d tag %0d dist %0d last %0d",
                              want.status, want.tag, want.distance, want.last);
            got_s = $sformatf("status %0d tag %0d dist %0d last %0d",
                              status_o, out_tag_o, out_distance_o, last_o);
            $display("%0t: mismatch: expected %s, got %s", $time, exp_s, got_s);
          end
        end
      end
      // long hold-off so the block backs up into its input
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      r = $urandom_range(0, 9);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready_i <= 1'b0;
      end else if (!no_idle && rcv_calm == 0 && r < 2) begin
        rcv_gap = $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        if (rcv_calm > 0) rcv_calm--;
        else if (!no_idle && r == 2) rcv_calm = $urandom_range(10, 40);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Phases
  initial begin : seq
    int k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: camera at reset origin
    push_item(drain_item());                                  // empty list
    push_item(add_item(10'h000, '0, '0, '0));                 // zero distance
    push_item(add_item(10'h3FF, COORD_MIN, COORD_MIN, COORD_MIN));
    push_item(add_item(10'h155, COORD_MAX, COORD_MAX, COORD_MAX));
    push_item(add_item(10'h2AA, 20'sd16, '0, '0));            // distance one
    push_item(add_item(10'h005, '0, 20'sd16, '0));            // tie, goes after
    push_item(add_item(10'h006, '0, '0, -20'sd16));           // tie again
    push_item(add_item(10'h007, 20'sd15, '0, '0));            // fraction dropped
    push_item(add_item(10'h008, -20'sd16, '0, '0));
    push_item(add_item(10'h009, '1, '1, '1));
    push_item(drain_item());
    push_item(drain_item());                                  // empty after drain
    push_item(add_item(10'h0F0, 20'sd100, -20'sd200, 20'sd300));
    push_item(drain_item());                                  // single entry
    wait_drained();

    // camera at the negative corner: largest distance
    write_camera(COORD_MIN, COORD_MIN, COORD_MIN);
    push_item(add_item(10'h200, COORD_MAX, COORD_MAX, COORD_MAX));
    push_item(add_item(10'h1FF, COORD_MIN, COORD_MIN, COORD_MIN));
    push_item(drain_item());
    queue_random(45);
    push_item(drain_item());
    wait_drained();

    // fill the list past its depth, then drain it whole
    write_camera(COORD_MAX, COORD_MIN, '0);
    for (k = 0; k < LIST_DEPTH + 2; k++) push_item(rand_add());
    push_item(drain_item());
    push_item(drain_item());
    wait_drained();

    // random camera, receiver holds off while items keep coming
    write_camera(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    queue_random(50);
    push_item(drain_item());
    hold_req <= 1'b1;
    wait_drained();

    // positive corner, no idling on either side
    no_idle = 1'b1;
    write_camera(COORD_MAX, COORD_MAX, COORD_MAX);
    queue_random(35);
    push_item(drain_item());
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dsdl_pkg.sv
hw/rtl/dsdl_dist.sv
hw/rtl/dsdl_cell.sv
hw/rtl/depth_sorted_draw_list_core.sv
verif/testbench.sv
